// ----- hw/rtl/dff_pkg.sv -----
// Shared types and constants of the decimal digit display formatter.
`default_nettype none

package dff_pkg;

  // Value types
  localparam logic [2:0] ModeU8  = 3'd0;
  localparam logic [2:0] ModeS8  = 3'd1;
  localparam logic [2:0] ModeU16 = 3'd2;
  localparam logic [2:0] ModeS16 = 3'd3;
  localparam logic [2:0] ModeU32 = 3'd4;
  localparam logic [2:0] ModeMin = 3'd5;

  localparam int ValueWidth = 32;
  localparam int BcdDigits  = 10;
  localparam int BcdWidth   = 4 * BcdDigits;
  localparam int DigIdxW    = $clog2(BcdDigits);
  localparam int NbitsW     = 6;
  localparam int MinWidth   = 16;

  localparam logic [NbitsW-1:0] NbitsByte = 6'd8;
  localparam logic [NbitsW-1:0] NbitsHalf = 6'd16;
  localparam logic [NbitsW-1:0] NbitsWord = 6'd32;

  // Maximum digit counts of the byte and halfword types
  localparam int DigitsByte = 3;
  localparam int DigitsHalf = 5;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiMinus = 8'h2d;

  localparam logic [6:0] MinPerHour = 7'd60;
  localparam logic [6:0] HhmmScale  = 7'd100;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [3:0]  start_position;
    logic [2:0]  digit_count;
  } dff_in_t;

  typedef struct packed {
    logic [3:0] position;
    logic [7:0] character;
    logic       last;
  } dff_out_t;

  typedef struct packed {
    logic              go;
    logic [NbitsW-1:0] nbits;
  } dff_conv_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dff_conv_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_digit_display_formatter_core.sv -----
// Per item: the hhmm type first runs a divide by 60 ahead of the BCD converter.
// The bit-serial BCD converter then takes 8, 16 or 32 value bits, by type.
// A digit pass over the ten BCD digits of its word follows.
// Then DISPLAY_WIDTH character beats leave at one per cycle when the sink is ready.
// One item at a time: the next item is accepted after the last beat of the run.
// Reset (rst_ni low, asynchronous) fills the display store with spaces and idles the block.
`default_nettype none

module decimal_digit_display_formatter_core #(
  parameter int DISPLAY_WIDTH = 10,
  parameter int MAX_DIGITS    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dff_pkg::dff_in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dff_pkg::dff_out_t  out_data_o
);

  localparam int IdxW  = $clog2(DISPLAY_WIDTH);
  localparam int CntW  = IdxW + 1;
  localparam int PosW  = $clog2(DISPLAY_WIDTH + 24) + 1;
  localparam int MaxdW = $clog2(MAX_DIGITS + 1);
  localparam int CmpW  = (MaxdW > dff_pkg::DigIdxW) ? MaxdW : dff_pkg::DigIdxW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMin  = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StConv = 3'd3;
  localparam logic [2:0] StDig  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [2:0]                     mode_q, mode_d;
  logic [31:0]                    value_q, value_d;
  logic [2:0]                     count_q, count_d;
  logic [PosW-1:0]                start_q, start_d;
  logic [PosW-1:0]                pos_q, pos_d;
  logic [7:0]                     acc_q, acc_d;
  logic [dff_pkg::BcdWidth-1:0]   dig_q, dig_d;
  logic [dff_pkg::DigIdxW-1:0]    digit_q, digit_d;
  logic [IdxW-1:0]                emit_idx_q, emit_idx_d;
  logic                           emit_all_q, emit_all_d;
  logic                           out_valid_q, out_valid_d;
  dff_pkg::dff_out_t              out_q, out_d;
  logic [7:0]                     store_q [DISPLAY_WIDTH];
  logic [7:0]                     store_d [DISPLAY_WIDTH];

  logic                           in_accept;
  logic                           blank;
  logic                           wr_en;
  logic [PosW-1:0]                wr_pos;
  logic [7:0]                     wr_char;
  logic                           wr_ok;
  logic [IdxW-1:0]                wr_idx;

  logic [CmpW-1:0]                maxd;
  logic [CmpW-1:0]                cnt_ext;
  logic                           digits_en;
  logic                           full_top;
  logic [3:0]                     dval;
  logic [10:0]                    acc_sum;
  logic [7:0]                     acc_next;
  logic [CmpW-1:0]                digit_p1;
  logic                           is_top;
  logic                           is_below;
  logic [CntW-1:0]                emit_pos;

  logic                           min_go;
  dff_pkg::dff_conv_sts_t         min_sts;
  logic [dff_pkg::MinWidth-1:0]   hhmm;
  dff_pkg::dff_conv_req_t         bcd_req;
  logic [dff_pkg::ValueWidth-1:0] bcd_data;
  dff_pkg::dff_conv_sts_t         bcd_sts;
  logic [dff_pkg::BcdWidth-1:0]   bcd;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign min_go     = in_accept && (in_data_i.mode == dff_pkg::ModeMin);

  dff_min_conv u_min_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (min_go),
    .minutes_i (in_data_i.value[dff_pkg::MinWidth-1:0]),
    .sts_o     (min_sts),
    .hhmm_o    (hhmm)
  );

  dff_bcd_conv u_bcd_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bcd_req),
    .data_i (bcd_data),
    .sts_o  (bcd_sts),
    .bcd_o  (bcd)
  );

  // Per-type digit limit
  always_comb begin
    case (mode_q)
      dff_pkg::ModeU8, dff_pkg::ModeS8:                   maxd = CmpW'(dff_pkg::DigitsByte);
      dff_pkg::ModeU16, dff_pkg::ModeS16, dff_pkg::ModeMin: maxd = CmpW'(dff_pkg::DigitsHalf);
      dff_pkg::ModeU32:                                   maxd = CmpW'(MAX_DIGITS);
      default:                                            maxd = '0;
    endcase
  end

  assign cnt_ext   = CmpW'(count_q);
  assign digits_en = (cnt_ext != '0) && (cnt_ext <= maxd);
  assign full_top  = (cnt_ext == maxd);

  // Horner over the BCD digits, top first: acc = floor(n / 10^i) mod 256
  assign dval     = dig_q[dff_pkg::BcdWidth-1 -: 4];
  assign acc_sum  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {7'd0, dval};
  assign acc_next = acc_sum[7:0];
  assign digit_p1 = CmpW'(digit_q) + CmpW'(1);
  assign is_top   = (digit_p1 == cnt_ext);
  assign is_below = (digit_p1 < cnt_ext);

  // Converter request, sized and aligned to the MSB per type
  always_comb begin
    bcd_req.go    = (state_q == StPrep);
    bcd_req.nbits = dff_pkg::NbitsWord;
    bcd_data      = value_q;
    case (mode_q)
      dff_pkg::ModeU8: begin
        bcd_req.nbits = dff_pkg::NbitsByte;
        bcd_data      = {value_q[7:0], 24'd0};
      end
      dff_pkg::ModeS8: begin
        bcd_req.nbits = dff_pkg::NbitsByte;
        bcd_data      = {(value_q[7] ? (8'd0 - value_q[7:0]) : value_q[7:0]), 24'd0};
      end
      dff_pkg::ModeU16: begin
        bcd_req.nbits = dff_pkg::NbitsHalf;
        bcd_data      = {value_q[15:0], 16'd0};
      end
      dff_pkg::ModeS16: begin
        bcd_req.nbits = dff_pkg::NbitsHalf;
        bcd_data      = {(value_q[15] ? (16'd0 - value_q[15:0]) : value_q[15:0]), 16'd0};
      end
      dff_pkg::ModeMin: begin
        bcd_req.nbits = dff_pkg::NbitsHalf;
        bcd_data      = {hhmm, 16'd0};
      end
      default: begin
        bcd_req.nbits = dff_pkg::NbitsWord;
        bcd_data      = value_q;
      end
    endcase
  end

  assign emit_pos = {1'b0, emit_idx_q} + CntW'(1);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    value_d     = value_q;
    count_d     = count_q;
    start_d     = start_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    dig_d       = dig_q;
    digit_d     = digit_q;
    emit_idx_d  = emit_idx_q;
    emit_all_d  = emit_all_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    blank       = 1'b0;
    wr_en       = 1'b0;
    wr_pos      = pos_q;
    wr_char     = 8'(dval) + dff_pkg::AsciiZero;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          mode_d  = in_data_i.mode;
          value_d = in_data_i.value;
          count_d = in_data_i.digit_count;
          if (in_data_i.start_position == 4'd0) begin
            blank   = 1'b1;
            start_d = PosW'(DISPLAY_WIDTH + 1) - PosW'(in_data_i.digit_count);
          end else begin
            start_d = PosW'(in_data_i.start_position);
          end
          state_d = (in_data_i.mode == dff_pkg::ModeMin) ? StMin : StPrep;
        end
      end
      StMin: begin
        if (min_sts.done) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        // place the minus sign left of the first digit
        wr_en   = ((mode_q == dff_pkg::ModeS8) && value_q[7]) ||
                  ((mode_q == dff_pkg::ModeS16) && value_q[15]);
        wr_pos  = start_q - PosW'(1);
        wr_char = dff_pkg::AsciiMinus;
        pos_d   = start_q + PosW'(count_q) - PosW'(dff_pkg::BcdDigits);
        acc_d   = '0;
        digit_d = dff_pkg::DigIdxW'(dff_pkg::BcdDigits - 1);
        state_d = StConv;
      end
      StConv: begin
        if (bcd_sts.done) begin
          dig_d   = bcd;
          state_d = StDig;
        end
      end
      StDig: begin
        wr_en   = digits_en && (is_top || is_below);
        wr_pos  = pos_q;
        wr_char = (is_top && full_top) ? (acc_next + dff_pkg::AsciiZero)
                                       : (8'(dval) + dff_pkg::AsciiZero);
        acc_d   = acc_next;
        dig_d   = {dig_q[dff_pkg::BcdWidth-5:0], 4'd0};
        pos_d   = pos_q + PosW'(1);
        digit_d = digit_q - dff_pkg::DigIdxW'(1);
        if (digit_q == '0) begin
          emit_idx_d = '0;
          emit_all_d = 1'b0;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          if (emit_all_q) begin
            out_valid_d = 1'b0;
            state_d     = StIdle;
          end else begin
            out_valid_d     = 1'b1;
            out_d.position  = emit_pos[3:0];
            out_d.character = store_q[emit_idx_q];
            out_d.last      = (emit_idx_q == IdxW'(DISPLAY_WIDTH - 1));
            if (emit_idx_q == IdxW'(DISPLAY_WIDTH - 1)) begin
              emit_all_d = 1'b1;
            end else begin
              emit_idx_d = emit_idx_q + IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Drop writes outside positions 1..DISPLAY_WIDTH
  assign wr_ok  = wr_en && !wr_pos[PosW-1] && (wr_pos != '0) &&
                  (wr_pos <= PosW'(DISPLAY_WIDTH));
  assign wr_idx = IdxW'(wr_pos - PosW'(1));

  always_comb begin
    for (int k = 0; k < DISPLAY_WIDTH; k++) begin
      store_d[k] = blank ? dff_pkg::AsciiSpace : store_q[k];
    end
    if (wr_ok) begin
      store_d[wr_idx] = wr_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      emit_idx_q  <= '0;
      emit_all_q  <= 1'b0;
      out_valid_q <= 1'b0;
      digit_q     <= '0;
      for (int k = 0; k < DISPLAY_WIDTH; k++) begin
        store_q[k] <= dff_pkg::AsciiSpace;
      end
    end else begin
      state_q     <= state_d;
      emit_idx_q  <= emit_idx_d;
      emit_all_q  <= emit_all_d;
      out_valid_q <= out_valid_d;
      digit_q     <= digit_d;
      for (int k = 0; k < DISPLAY_WIDTH; k++) begin
        store_q[k] <= store_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    value_q <= value_d;
    count_q <= count_d;
    start_q <= start_d;
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    dig_q   <= dig_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dff_min_conv.sv -----
// Bit-serial minutes to hhmm converter: restoring divide by 60, then recombine.
`default_nettype none

module dff_min_conv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [dff_pkg::MinWidth-1:0]  minutes_i,
  output dff_pkg::dff_conv_sts_t             sts_o,
  output logic      [dff_pkg::MinWidth-1:0]  hhmm_o
);

  localparam int CntW = $clog2(dff_pkg::MinWidth + 2);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [dff_pkg::MinWidth-1:0]  num_q, num_d;
  logic [5:0]                    rem_q, rem_d;
  logic [dff_pkg::MinWidth-1:0]  res_q, res_d;
  logic [6:0]                    trial;
  logic                          ge;

  assign trial = {rem_q, num_q[dff_pkg::MinWidth-1]};
  assign ge    = (trial >= dff_pkg::MinPerHour);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(dff_pkg::MinWidth + 1);
      num_d  = minutes_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        // num_q now holds the hours, rem_q the minutes
        res_d  = dff_pkg::MinWidth'(num_q * dff_pkg::HhmmScale)
               + dff_pkg::MinWidth'(rem_q);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d = ge ? 6'(trial - dff_pkg::MinPerHour) : trial[5:0];
        num_d = {num_q[dff_pkg::MinWidth-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign hhmm_o     = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dff_bcd_conv.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`default_nettype none

module dff_bcd_conv (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dff_pkg::dff_conv_req_t          req_i,
  input  wire logic [dff_pkg::ValueWidth-1:0]  data_i,
  output dff_pkg::dff_conv_sts_t               sts_o,
  output logic      [dff_pkg::BcdWidth-1:0]    bcd_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [dff_pkg::NbitsW-1:0]        cnt_q, cnt_d;
  logic [dff_pkg::ValueWidth-1:0]    bin_q, bin_d;
  logic [dff_pkg::BcdWidth-1:0]      bcd_q, bcd_d;
  logic [dff_pkg::BcdWidth-1:0]      adj;

  function automatic logic [3:0] add3(input logic [3:0] n);
    return (n >= 4'd5) ? (n + 4'd3) : n;
  endfunction

  always_comb begin
    for (int k = 0; k < dff_pkg::BcdDigits; k++) begin
      adj[4*k +: 4] = add3(bcd_q[4*k +: 4]);
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      bin_d  = data_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      // shift the next MSB into the adjusted digits
      bcd_d = {adj[dff_pkg::BcdWidth-2:0], bin_q[dff_pkg::ValueWidth-1]};
      bin_d = {bin_q[dff_pkg::ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q - dff_pkg::NbitsW'(1);
      if (cnt_q == dff_pkg::NbitsW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bcd_o      = bcd_q;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the decimal digit display formatter: scoreboard class, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int DispWidth  = 10;
  localparam int MaxDigits  = 6;
  localparam int CycleLimit = 600000;
  localparam int TailCycles = 80;
  localparam int LongHold   = 400;
  localparam int ReportCap  = 10;

  // Modes outside the package's list; the block writes no digits for them, but still blanks and emits.
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  // Tracks the display store and the character beats each item should produce.
  class display_tracker;
    logic [7:0]         shown [1:DispWidth];
    dff_pkg::dff_out_t  pending_chars [$];
    int                 failures;

    function new();
      foreach (shown[p]) shown[p] = dff_pkg::AsciiSpace;
      failures = 0;
    endfunction

    function void place_char(int pos, logic [7:0] ch);
      if (pos >= 1 && pos <= DispWidth) shown[pos] = ch;
    endfunction

    function longint unsigned ten_power(int k);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < k; i++) p = p * 10;
      return p;
    endfunction

    function void write_digits(longint unsigned n, int start, int count, int max_digits);
      longint unsigned d;
      if (count == 0 || count > max_digits) return;
      if (count < max_digits) n = n % ten_power(count);
      for (int j = 0; j < count; j++) begin
        d = n / ten_power(count - 1 - j);
        // top digit may exceed 9; its character wraps
        if (j > 0) d = d % 10;
        place_char(start + j, 8'(d + dff_pkg::AsciiZero));
      end
    endfunction

    function void note_item(dff_pkg::dff_in_t item);
      int                 start;
      int                 count;
      logic [7:0]         byte_mag;
      logic [15:0]        half_mag;
      longint unsigned    minutes;
      dff_pkg::dff_out_t  beat;
      count = int'(item.digit_count);
      start = int'(item.start_position);
      if (start == 0) begin
        start = DispWidth + 1 - count;
        foreach (shown[p]) shown[p] = dff_pkg::AsciiSpace;
      end
      case (item.mode)
        dff_pkg::ModeU8: write_digits(item.value[7:0], start, count, dff_pkg::DigitsByte);
        dff_pkg::ModeS8: begin
          byte_mag = item.value[7:0];
          if (byte_mag[7]) begin
            byte_mag = 8'h00 - byte_mag;
            place_char(start - 1, dff_pkg::AsciiMinus);
          end
          write_digits(byte_mag, start, count, dff_pkg::DigitsByte);
        end
        dff_pkg::ModeU16: write_digits(item.value[15:0], start, count, dff_pkg::DigitsHalf);
        dff_pkg::ModeS16: begin
          half_mag = item.value[15:0];
          if (half_mag[15]) begin
            half_mag = 16'h0000 - half_mag;
            place_char(start - 1, dff_pkg::AsciiMinus);
          end
          write_digits(half_mag, start, count, dff_pkg::DigitsHalf);
        end
        dff_pkg::ModeU32: write_digits(item.value, start, count, MaxDigits);
        dff_pkg::ModeMin: begin
          minutes = item.value[15:0];
          minutes = ((minutes / 60) * 100 + minutes % 60) & 64'hffff;
          write_digits(minutes, start, count, dff_pkg::DigitsHalf);
        end
        default: ;
      endcase
      for (int p = 1; p <= DispWidth; p++) begin
        beat.position  = 4'(p);
        beat.character = shown[p];
        beat.last      = (p == DispWidth);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_beat(dff_pkg::dff_out_t got);
      dff_pkg::dff_out_t want;
      if (pending_chars.size() == 0) begin
        failures++;
        if (failures <= ReportCap)
          $display("unexpected beat: pos %0d char %02h last %0b",
                   got.position, got.character, got.last);
        return;
      end
      want = pending_chars.pop_front();
      if (got.position !== want.position || got.character !== want.character ||
          got.last !== want.last) begin
        failures++;
        if (failures <= ReportCap)
          $display({"mismatch: expected pos %0d char %02h last %0b, ",
                    "got pos %0d char %02h last %0b"},
                   want.position, want.character, want.last,
                   got.position, got.character, got.last);
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  dff_pkg::dff_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  dff_pkg::dff_out_t out_data_o;

  int src_idle_pct  = 10;
  int sink_idle_pct = 83;
  int sink_hold     = 0;
  int cycle_count   = 0;

  display_tracker board;

  decimal_digit_display_formatter_core #(
    .DISPLAY_WIDTH(DispWidth),
    .MAX_DIGITS   (MaxDigits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sample both channels at the rising edge; the input beat is noted first.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_item(in_data_i);
      if (out_valid_o && out_ready_i) board.check_beat(out_data_o);
    end
  end

  // Drive the sink's ready; a pending hold-off overrides the random pattern.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_ready_i <= 1'b0;
      sink_hold   <= sink_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic send_item(input logic [2:0] mode, input logic [31:0] value,
                           input logic [3:0] start, input logic [2:0] count);
    dff_pkg::dff_in_t item;
    item.mode           = mode;
    item.value          = value;
    item.start_position = start;
    item.digit_count    = count;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected character has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int items);
    logic [31:0] edge_values [10];
    logic [2:0]  mode;
    logic [31:0] value;
    logic [3:0]  start;
    logic [2:0]  count;
    int          pick;
    edge_values = '{32'h0, 32'h7f, 32'h80, 32'hff, 32'h7fff, 32'h8000, 32'hffff,
                    32'd99999, 32'd999999, 32'hffffffff};
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) mode = $urandom_range(0, 1) ? ModeSpare6 : ModeSpare7;
      else mode = 3'($urandom_range(dff_pkg::ModeU8, dff_pkg::ModeMin));
      case ($urandom_range(0, 5))
        0: value = $urandom();
        1: value = $urandom_range(0, 999);
        2: value = $urandom_range(0, 99999);
        3: value = edge_values[$urandom_range(0, 9)];
        4: value = $urandom_range(900000, 1100000);
        default: value = $urandom() & 32'hffff;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 3) start = 4'd0;
      else if (pick < 9) start = 4'($urandom_range(1, DispWidth));
      else start = 4'($urandom_range(DispWidth + 1, 15));
      if ($urandom_range(0, 9) == 0) count = $urandom_range(0, 1) ? 3'd0 : 3'd7;
      else count = 3'($urandom_range(1, MaxDigits));
      send_item(mode, value, start, count);
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes, sign handling, wrap of the top digit, dropped writes
    send_item(dff_pkg::ModeU8,  32'd255,        4'd0,  3'd3);
    send_item(dff_pkg::ModeU8,  32'd0,          4'd1,  3'd1);
    send_item(dff_pkg::ModeS8,  32'h80,         4'd0,  3'd3);
    send_item(dff_pkg::ModeS8,  32'h7f,         4'd5,  3'd3);
    send_item(dff_pkg::ModeS8,  32'hff,         4'd1,  3'd3);
    send_item(dff_pkg::ModeU16, 32'hffff,       4'd0,  3'd5);
    send_item(dff_pkg::ModeS16, 32'h8000,       4'd0,  3'd5);
    send_item(dff_pkg::ModeU32, 32'hffffffff,   4'd0,  3'd6);
    send_item(dff_pkg::ModeU32, 32'd123456,     4'd5,  3'd6);
    send_item(dff_pkg::ModeU32, 32'hffffffff,   4'd1,  3'd4);
    send_item(dff_pkg::ModeMin, 32'd1439,       4'd0,  3'd4);
    send_item(dff_pkg::ModeMin, 32'hffff,       4'd0,  3'd5);
    send_item(dff_pkg::ModeU8,  32'd1,          4'd3,  3'd0);
    send_item(dff_pkg::ModeU8,  32'd7,          4'd0,  3'd4);
    send_item(dff_pkg::ModeS8,  32'h80,         4'd4,  3'd0);
    send_item(ModeSpare6,       32'd12345,      4'd0,  3'd3);
    send_item(ModeSpare7,       32'd12345,      4'd2,  3'd3);
    send_item(dff_pkg::ModeU16, 32'd54321,      4'd9,  3'd5);
    send_item(dff_pkg::ModeU32, 32'd654321,     4'd15, 3'd6);
    send_item(dff_pkg::ModeS16, 32'hffff,       4'd11, 3'd1);
    send_item(dff_pkg::ModeU8,  32'd200,        4'd1,  3'd7);
    send_item(dff_pkg::ModeU32, 32'd999999,     4'd0,  3'd6);
    send_item(dff_pkg::ModeU32, 32'd1000000,    4'd0,  3'd6);
    send_item(dff_pkg::ModeU16, 32'hfffa0005,   4'd0,  3'd2);
    send_item(dff_pkg::ModeS16, 32'h0001,       4'd6,  3'd5);
    wait_drained();

    run_random(75);
    wait_drained();

    src_idle_pct  = 83;
    sink_idle_pct = 10;
    run_random(75);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(30);
    // Stall the sink for a long stretch while items keep coming
    sink_hold = LongHold;
    run_random(10);
    wait_drained();
    run_random(5);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (board.pending_chars.size() != 0)
      $display("%0d expected characters never emitted", board.pending_chars.size());
    if (board.failures == 0 && board.pending_chars.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dff_pkg.sv
hw/rtl/dff_min_conv.sv
hw/rtl/dff_bcd_conv.sv
hw/rtl/decimal_digit_display_formatter_core.sv
test/tb_top.sv
